// ----- hdl/blfc_pkg.sv -----
// blfc_pkg: shared types and fixed constants for the beam local frame cosine block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package blfc_pkg;

    // field widths fixed by the interface
    localparam int COORD_W    = 24;
    localparam int OUT_W      = 16;

    // normalize datapath
    localparam int NORM_W     = 24;   // magnitudes are brought below 2^NORM_W
    localparam int SQRT_PRE   = 12;   // sum of squares is scaled by 2^SQRT_PRE before the root
    localparam int ISQ_IN_W   = 62;   // radicand width
    localparam int ISQ_ROOT_W = 31;   // root width
    localparam int COS_GUARD  = 6;    // extra quotient scale matching sqrt(2^SQRT_PRE)
    localparam int DIV_W      = 64;   // divider remainder width

    // input transfer
    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
    } point_t;

    // output transfer
    typedef struct packed {
        logic signed [OUT_W-1:0] xl;
        logic signed [OUT_W-1:0] xm;
        logic signed [OUT_W-1:0] xn;
        logic signed [OUT_W-1:0] yl;
        logic signed [OUT_W-1:0] ym;
        logic signed [OUT_W-1:0] yn;
        logic signed [OUT_W-1:0] zl;
        logic signed [OUT_W-1:0] zm;
        logic signed [OUT_W-1:0] zn;
        logic                    degenerate;
    } frame_t;

    // control that travels alongside an item through the normalize pipeline
    typedef struct packed {
        logic valid;
        logic degen;
    } tag_t;

endpackage

`default_nettype wire

// ----- hdl/blfc_isqrt.sv -----
// blfc_isqrt: pipelined floor square root, one root bit per stage
// depends on blfc_pkg; carries a side word with the same latency
`timescale 1ns / 1ps
`default_nettype none

module blfc_isqrt
    import blfc_pkg::*;
#(
    parameter int SIDE_W = 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [ISQ_IN_W-1:0]   rad,
    input  logic [SIDE_W-1:0]     side_in,
    output logic [ISQ_ROOT_W-1:0] root,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int R  = ISQ_ROOT_W;
    localparam int RW = ISQ_IN_W + 2;

    logic [RW-1:0]         rem_reg  [R-1];
    logic [ISQ_ROOT_W-1:0] root_reg [R];
    logic [SIDE_W-1:0]     side_reg [R];

    for (genvar k = 0; k < R; k++)
    begin : g_step
        localparam int J = R - 1 - k;
        logic [RW-1:0]         rem_prev;
        logic [RW-1:0]         trial;
        logic [ISQ_ROOT_W-1:0] root_prev;
        logic [ISQ_ROOT_W-1:0] root_next;
        logic [SIDE_W-1:0]     side_prev;
        logic                  take;

        if (k == 0)
        begin : g_first
            assign rem_prev  = RW'(rad);
            assign root_prev = '0;
            assign side_prev = side_in;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // trial subtrahend (2*root + bit) * bit
        assign trial     = (RW'(root_prev) << (J + 1)) + (RW'(1) << (2 * J));
        assign take      = (rem_prev >= trial);
        assign root_next = take ? (root_prev | (ISQ_ROOT_W'(1) << J)) : root_prev;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k] <= '0;
            end
            else if (en)
            begin
                side_reg[k] <= side_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= root_next;
            end
        end

        if (k < R - 1)
        begin : g_rem
            logic [RW-1:0] rem_next;
            assign rem_next = take ? (rem_prev - trial) : rem_prev;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign root     = root_reg[R-1];
    assign side_out = side_reg[R-1];

endmodule

`default_nettype wire

// ----- hdl/blfc_unitize.sv -----
// blfc_unitize: pipelined normalize of a 3-vector to fixed-point direction cosines
// depends on blfc_pkg and blfc_isqrt
`timescale 1ns / 1ps
`default_nettype none

module blfc_unitize
    import blfc_pkg::*;
#(
    parameter int VW            = 25,
    parameter int TAG_W         = 2,
    parameter int COS_FRAC_BITS = 14
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic [2:0][VW-1:0]             vec,
    input  logic [TAG_W-1:0]               tag_in,
    output logic [2:0][COS_FRAC_BITS+1:0]  cos,
    output logic [TAG_W-1:0]               tag_out
);

    localparam int QB     = COS_FRAC_BITS + 2;
    localparam int SW     = $clog2(VW);
    localparam int SQ_W   = 2 * NORM_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int SIDE_W = TAG_W + 3 + 3 * NORM_W;
    localparam logic [QB-1:0] QONE = QB'(1) << COS_FRAC_BITS;

    // stage 1: magnitudes and signs
    logic [2:0][VW-1:0]     mag1_next, mag1_reg;
    logic [2:0]             sgn1_reg;
    logic [TAG_W-1:0]       tag1_reg;
    // stage 2: right shift that brings the largest below 2^NORM_W
    logic [VW-1:0]          or_w;
    logic [SW-1:0]          shift2_next, shift2_reg;
    logic [2:0][VW-1:0]     mag2_reg;
    logic [2:0]             sgn2_reg;
    logic [TAG_W-1:0]       tag2_reg;
    // stage 3: shifted magnitudes
    logic [2:0][NORM_W-1:0] w3_next, w3_reg;
    logic [2:0]             sgn3_reg;
    logic [TAG_W-1:0]       tag3_reg;
    // stage 4: squares
    logic [2:0][SQ_W-1:0]   sq4_next, sq4_reg;
    logic [2:0][NORM_W-1:0] w4_reg;
    logic [2:0]             sgn4_reg;
    logic [TAG_W-1:0]       tag4_reg;
    // stage 5: radicand
    logic [SUM_W-1:0]       sum5;
    logic [ISQ_IN_W-1:0]    rad5_next, rad5_reg;
    logic [2:0][NORM_W-1:0] w5_reg;
    logic [2:0]             sgn5_reg;
    logic [TAG_W-1:0]       tag5_reg;
    // root pipeline
    logic [ISQ_ROOT_W-1:0]  root;
    logic [SIDE_W-1:0]      side_out;
    logic [TAG_W-1:0]       tag_r;
    logic [2:0]             sgn_r;
    logic [2:0][NORM_W-1:0] w_r;
    // stage n: guarded divisor
    logic [ISQ_ROOT_W-1:0]  n6_next, n6_reg;
    logic [2:0][NORM_W-1:0] w6_reg;
    logic [2:0]             sgn6_reg;
    logic [TAG_W-1:0]       tag6_reg;
    // stage num: rounded dividends
    logic [2:0][DIV_W-1:0]  num7_next, num7_reg;
    logic [ISQ_ROOT_W-1:0]  n7_reg;
    logic [2:0]             sgn7_reg;
    logic [TAG_W-1:0]       tag7_reg;
    // divider stages
    logic [2:0][DIV_W-1:0]  drem_reg [QB-1];
    logic [ISQ_ROOT_W-1:0]  dn_reg   [QB-1];
    logic [2:0][QB-1:0]     dq_reg   [QB];
    logic [2:0]             dsgn_reg [QB];
    logic [TAG_W-1:0]       dtag_reg [QB];
    // clamp and sign
    logic [2:0][QB-1:0]     cos_next, cos_reg;
    logic [TAG_W-1:0]       ctag_reg;

    // magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_next[i] = vec[i][VW-1] ? (~vec[i] + VW'(1)) : vec[i];
        end
    end

    // shift from the leading one of the combined magnitudes
    assign or_w = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];

    always_comb
    begin
        shift2_next = '0;
        for (int b = NORM_W; b < VW; b++)
        begin
            if (or_w[b])
            begin
                shift2_next = SW'(b - NORM_W + 1);
            end
        end
    end

    // shifted magnitudes and squares
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w3_next[i]  = NORM_W'(mag2_reg[i] >> shift2_reg);
            sq4_next[i] = SQ_W'(w3_reg[i]) * SQ_W'(w3_reg[i]);
        end
    end

    // sum of squares, scaled for the root
    assign sum5      = SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) + SUM_W'(sq4_reg[2]);
    assign rad5_next = ISQ_IN_W'(sum5) << SQRT_PRE;

    blfc_isqrt #(
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .rad      (rad5_reg),
        .side_in  ({tag5_reg, sgn5_reg, w5_reg}),
        .root     (root),
        .side_out (side_out)
    );

    assign {tag_r, sgn_r, w_r} = side_out;

    // divisor never zero
    assign n6_next = (root == '0) ? ISQ_ROOT_W'(1) : root;

    // dividends with half the divisor added for round half up
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num7_next[i] = (DIV_W'(w6_reg[i]) << (COS_FRAC_BITS + COS_GUARD))
                         + DIV_W'(n6_reg >> 1);
        end
    end

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
            tag6_reg <= '0;
            tag7_reg <= '0;
            ctag_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
            tag6_reg <= tag_r;
            tag7_reg <= tag6_reg;
            ctag_reg <= dtag_reg[QB-1];
        end
    end

    // front payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg   <= mag1_next;
            sgn1_reg   <= {vec[2][VW-1], vec[1][VW-1], vec[0][VW-1]};
            shift2_reg <= shift2_next;
            mag2_reg   <= mag1_reg;
            sgn2_reg   <= sgn1_reg;
            w3_reg     <= w3_next;
            sgn3_reg   <= sgn2_reg;
            sq4_reg    <= sq4_next;
            w4_reg     <= w3_reg;
            sgn4_reg   <= sgn3_reg;
            rad5_reg   <= rad5_next;
            w5_reg     <= w4_reg;
            sgn5_reg   <= sgn4_reg;
            n6_reg     <= n6_next;
            w6_reg     <= w_r;
            sgn6_reg   <= sgn_r;
            num7_reg   <= num7_next;
            n7_reg     <= n6_reg;
            sgn7_reg   <= sgn6_reg;
            cos_reg    <= cos_next;
        end
    end

    // restoring divider, one quotient bit per stage, three lanes share the divisor
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int J = QB - 1 - k;
        logic [2:0][DIV_W-1:0]  rem_prev;
        logic [ISQ_ROOT_W-1:0]  n_prev;
        logic [2:0][QB-1:0]     q_prev;
        logic [2:0][QB-1:0]     q_next;
        logic [2:0]             sgn_prev;
        logic [TAG_W-1:0]       tag_prev;
        logic [DIV_W-1:0]       dvs;
        logic [2:0]             take;

        if (k == 0)
        begin : g_first
            assign rem_prev = num7_reg;
            assign n_prev   = n7_reg;
            assign q_prev   = '0;
            assign sgn_prev = sgn7_reg;
            assign tag_prev = tag7_reg;
        end
        else
        begin : g_rest
            assign rem_prev = drem_reg[k-1];
            assign n_prev   = dn_reg[k-1];
            assign q_prev   = dq_reg[k-1];
            assign sgn_prev = dsgn_reg[k-1];
            assign tag_prev = dtag_reg[k-1];
        end

        assign dvs = DIV_W'(n_prev) << J;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                take[i]   = (rem_prev[i] >= dvs);
                q_next[i] = take[i] ? (q_prev[i] | (QB'(1) << J)) : q_prev[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dtag_reg[k] <= '0;
            end
            else if (en)
            begin
                dtag_reg[k] <= tag_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg[k]   <= q_next;
                dsgn_reg[k] <= sgn_prev;
            end
        end

        if (k < QB - 1)
        begin : g_rem
            logic [2:0][DIV_W-1:0] rem_next;
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_next[i] = take[i] ? (rem_prev[i] - dvs) : rem_prev[i];
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    drem_reg[k] <= rem_next;
                    dn_reg[k]   <= n_prev;
                end
            end
        end
    end

    // clamp to one and restore the sign
    always_comb
    begin
        logic [QB-1:0] qc;
        for (int i = 0; i < 3; i++)
        begin
            qc          = (dq_reg[QB-1][i] > QONE) ? QONE : dq_reg[QB-1][i];
            cos_next[i] = dsgn_reg[QB-1][i] ? (~qc + QB'(1)) : qc;
        end
    end

    assign cos     = cos_reg;
    assign tag_out = ctag_reg;

endmodule

`default_nettype wire

// ----- hdl/beam_local_frame_cosines.sv -----
// beam_local_frame_cosines: direction cosines of a beam element's local frame
// the root and divider stages make up most of the pipeline depth
// throughput one element per cycle; the whole pipeline holds while a result is stalled
// reset clears all valid bits; no clearing pass, accepts from the first edge after release
// depends on blfc_pkg and blfc_unitize
`timescale 1ns / 1ps
`default_nettype none

module beam_local_frame_cosines
    import blfc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int COS_FRAC_BITS   = 14
)(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   point_valid,
    output logic   point_stall,
    input  point_t point_data,
    output logic   frame_valid,
    input  logic   frame_stall,
    output frame_t frame_data
);

    localparam int DW  = COORD_W + 1;
    localparam int EW  = ((COORD_FRAC_BITS + 2 > DW) ? COORD_FRAC_BITS + 2 : DW) + 1;
    localparam int PW  = DW + EW;
    localparam int CXW = PW + 1;
    localparam int CW  = COS_FRAC_BITS + 2;
    localparam int YPW = 2 * CW;
    localparam int YW  = YPW + 1;

    logic en;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    point_t                pt_reg;
    logic signed [DW-1:0]  d_next  [3];
    logic signed [DW-1:0]  d_reg   [3];
    logic signed [EW-1:0]  e_s     [3];
    logic signed [PW-1:0]  p_next  [6];
    logic signed [PW-1:0]  p_reg   [6];
    logic signed [DW-1:0]  d3_reg  [3];
    logic signed [DW-1:0]  d4_reg  [3];
    logic                  dz3_next, dz3_reg, dz4_reg;
    logic signed [CXW-1:0] c_next  [3];
    logic signed [CXW-1:0] c_reg   [3];

    logic [2:0][CXW-1:0]   c_vec;
    logic [2:0][DW-1:0]    d_vec;
    tag_t                  ctag_in, ctag_out;
    logic                  x_valid, z_degen;
    logic [2:0][CW-1:0]    ux_w, uz_w;

    logic signed [CW-1:0]  ux_s    [3];
    logic signed [CW-1:0]  uz_s    [3];
    logic signed [YPW-1:0] yp_next [6];
    logic signed [YPW-1:0] yp_reg  [6];
    logic signed [CW-1:0]  ux5_reg [3];
    logic signed [CW-1:0]  uz5_reg [3];
    tag_t                  t5_reg;
    logic signed [CW-1:0]  yv      [3];
    frame_t                frame_next, frame_reg;
    logic                  frame_valid_reg;

    // pipeline advances unless a finished result is held
    assign en          = !(frame_valid_reg && frame_stall);
    assign point_stall = !en;

    // axis vector
    assign d_next[0] = DW'(pt_reg.b_x) - DW'(pt_reg.a_x);
    assign d_next[1] = DW'(pt_reg.b_y) - DW'(pt_reg.a_y);
    assign d_next[2] = DW'(pt_reg.b_z) - DW'(pt_reg.a_z);

    // offset e = d/2 + (0.5, 1, 0) in half units, and the cross product terms
    assign e_s[0] = EW'(d_reg[0]) + (EW'(1) << COORD_FRAC_BITS);
    assign e_s[1] = EW'(d_reg[1]) + (EW'(1) << (COORD_FRAC_BITS + 1));
    assign e_s[2] = EW'(d_reg[2]);

    assign p_next[0] = PW'(d_reg[1]) * PW'(e_s[2]);
    assign p_next[1] = PW'(d_reg[2]) * PW'(e_s[1]);
    assign p_next[2] = PW'(d_reg[2]) * PW'(e_s[0]);
    assign p_next[3] = PW'(d_reg[0]) * PW'(e_s[2]);
    assign p_next[4] = PW'(d_reg[0]) * PW'(e_s[1]);
    assign p_next[5] = PW'(d_reg[1]) * PW'(e_s[0]);

    assign dz3_next = (d_reg[0] == '0) && (d_reg[1] == '0) && (d_reg[2] == '0);

    assign c_next[0] = CXW'(p_reg[0]) - CXW'(p_reg[1]);
    assign c_next[1] = CXW'(p_reg[2]) - CXW'(p_reg[3]);
    assign c_next[2] = CXW'(p_reg[4]) - CXW'(p_reg[5]);

    // front control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= point_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // front payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg  <= point_data;
            d_reg   <= d_next;
            p_reg   <= p_next;
            d3_reg  <= d_reg;
            dz3_reg <= dz3_next;
            c_reg   <= c_next;
            d4_reg  <= d3_reg;
            dz4_reg <= dz3_reg;
        end
    end

    // normalize both axes in lockstep
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_vec[i] = c_reg[i];
            d_vec[i] = d4_reg[i];
        end
    end

    assign ctag_in.valid = v4_reg;
    assign ctag_in.degen = dz4_reg
                         || ((c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0));

    // valid rides the x unit, degenerate flag the z unit
    blfc_unitize #(
        .VW            (DW),
        .TAG_W         (1),
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_unit_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vec     (d_vec),
        .tag_in  (ctag_in.valid),
        .cos     (ux_w),
        .tag_out (x_valid)
    );

    blfc_unitize #(
        .VW            (CXW),
        .TAG_W         (1),
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_unit_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vec     (c_vec),
        .tag_in  (ctag_in.degen),
        .cos     (uz_w),
        .tag_out (z_degen)
    );

    assign ctag_out = '{valid: x_valid, degen: z_degen};

    // y = z cross x, products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ux_s[i] = $signed(ux_w[i]);
            uz_s[i] = $signed(uz_w[i]);
        end
    end

    assign yp_next[0] = YPW'(uz_s[1]) * YPW'(ux_s[2]);
    assign yp_next[1] = YPW'(uz_s[2]) * YPW'(ux_s[1]);
    assign yp_next[2] = YPW'(uz_s[2]) * YPW'(ux_s[0]);
    assign yp_next[3] = YPW'(uz_s[0]) * YPW'(ux_s[2]);
    assign yp_next[4] = YPW'(uz_s[0]) * YPW'(ux_s[1]);
    assign yp_next[5] = YPW'(uz_s[1]) * YPW'(ux_s[0]);

    // difference, round half away from zero, clamp magnitude to one
    always_comb
    begin
        logic signed [YW-1:0] diff;
        logic [YW-1:0]        mag;
        logic [YW-1:0]        rq;
        logic [CW-1:0]        qc;
        for (int i = 0; i < 3; i++)
        begin
            diff  = YW'(yp_reg[2*i]) - YW'(yp_reg[2*i+1]);
            mag   = diff[YW-1] ? (~diff + YW'(1)) : diff;
            rq    = (mag + (YW'(1) << (COS_FRAC_BITS - 1))) >> COS_FRAC_BITS;
            if (rq > (YW'(1) << COS_FRAC_BITS))
            begin
                rq = YW'(1) << COS_FRAC_BITS;
            end
            qc    = CW'(rq);
            yv[i] = diff[YW-1] ? (~qc + CW'(1)) : qc;
        end
    end

    // output word, zeros for a degenerate element
    always_comb
    begin
        frame_next = '0;
        frame_next.degenerate = t5_reg.degen;
        if (!t5_reg.degen)
        begin
            frame_next.xl = OUT_W'(ux5_reg[0]);
            frame_next.xm = OUT_W'(ux5_reg[1]);
            frame_next.xn = OUT_W'(ux5_reg[2]);
            frame_next.yl = OUT_W'(yv[0]);
            frame_next.ym = OUT_W'(yv[1]);
            frame_next.yn = OUT_W'(yv[2]);
            frame_next.zl = OUT_W'(uz5_reg[0]);
            frame_next.zm = OUT_W'(uz5_reg[1]);
            frame_next.zn = OUT_W'(uz5_reg[2]);
        end
    end

    // back control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t5_reg          <= '0;
            frame_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t5_reg          <= ctag_out;
            frame_valid_reg <= t5_reg.valid;
        end
    end

    // back payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yp_reg    <= yp_next;
            ux5_reg   <= ux_s;
            uz5_reg   <= uz_s;
            frame_reg <= frame_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame_data  = frame_reg;

endmodule

`default_nettype wire

// ----- hdl/blfc_checker.sv -----
// blfc_checker: port-level assertions for beam_local_frame_cosines
// depends on blfc_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module blfc_checker
    import blfc_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   point_valid,
    input wire logic   point_stall,
    input wire point_t point_data,
    input wire logic   frame_valid,
    input wire logic   frame_stall,
    input wire frame_t frame_data
);

    // a held result stays and does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_stall |=> frame_valid && $stable(frame_data))
        else $error("held result changed or dropped");

    // input is stalled only while a result is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> frame_valid && frame_stall)
        else $error("input stalled without a held result");

    // degenerate element carries zero cosines
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_data.degenerate |->
            frame_data.xl == '0 && frame_data.xm == '0 && frame_data.xn == '0 &&
            frame_data.yl == '0 && frame_data.ym == '0 && frame_data.yn == '0 &&
            frame_data.zl == '0 && frame_data.zm == '0 && frame_data.zn == '0)
        else $error("degenerate result with nonzero cosines");

endmodule

bind beam_local_frame_cosines blfc_checker u_blfc_checker (.*);

`default_nettype wire

// ----- verif/tb_beam_local_frame_cosines.sv -----
// tb_beam_local_frame_cosines: self-checking bench for the beam local frame cosine block
// drives random and directed end points, predicts the cosines in a scoreboard class
// depends on blfc_pkg and beam_local_frame_cosines
`timescale 1ns / 1ps

module tb_beam_local_frame_cosines
    import blfc_pkg::*;
();

    localparam int CFB = 16;
    localparam int KFB = 14;
    localparam int LATENCY = 47 + KFB;
    localparam longint CYCLE_LIMIT = 400000;

    // scoreboard: predicts one frame per accepted element and checks results in order
    class frame_scoreboard;
        frame_t pending[$];
        int errors;

        function longint unsigned mag(longint v);
            mag = (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            root_floor = r;
        endfunction

        // unit vector of v, components scaled by 2^KFB
        function void unit_vec(input longint v[3], output longint u[3]);
            longint unsigned m[3];
            longint unsigned mx, acc, n, q;
            int sh;
            mx = 0;
            acc = 0;
            sh = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = mag(v[i]);
                if (m[i] > mx)
                    mx = m[i];
            end
            while ((mx >> sh) >= (64'd1 << 24))
                sh++;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = m[i] >> sh;
                acc = acc + m[i] * m[i];
            end
            n = root_floor(acc << 12);
            if (n == 0)
                n = 1;
            for (int i = 0; i < 3; i++)
            begin
                q = ((m[i] << (KFB + 6)) + n / 2) / n;
                if (q > (64'd1 << KFB))
                    q = 64'd1 << KFB;
                u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
        endfunction

        function longint round_cos(longint p);
            longint unsigned q;
            q = (mag(p) + (64'd1 << (KFB - 1))) >> KFB;
            if (q > (64'd1 << KFB))
                q = 64'd1 << KFB;
            round_cos = (p < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void note_element(point_t p);
            longint d[3], e[3], c[3], ux[3], uy[3], uz[3];
            frame_t f;
            d[0] = longint'(p.b_x) - longint'(p.a_x);
            d[1] = longint'(p.b_y) - longint'(p.a_y);
            d[2] = longint'(p.b_z) - longint'(p.a_z);
            e[0] = d[0] + (64'sd1 <<< CFB);
            e[1] = d[1] + (64'sd1 <<< (CFB + 1));
            e[2] = d[2];
            c[0] = d[1] * e[2] - d[2] * e[1];
            c[1] = d[2] * e[0] - d[0] * e[2];
            c[2] = d[0] * e[1] - d[1] * e[0];
            f = '0;
            if ((d[0] == 0 && d[1] == 0 && d[2] == 0) || (c[0] == 0 && c[1] == 0 && c[2] == 0))
                f.degenerate = 1'b1;
            else
            begin
                unit_vec(d, ux);
                unit_vec(c, uz);
                uy[0] = round_cos(uz[1] * ux[2] - uz[2] * ux[1]);
                uy[1] = round_cos(uz[2] * ux[0] - uz[0] * ux[2]);
                uy[2] = round_cos(uz[0] * ux[1] - uz[1] * ux[0]);
                f.xl = ux[0][15:0];
                f.xm = ux[1][15:0];
                f.xn = ux[2][15:0];
                f.yl = uy[0][15:0];
                f.ym = uy[1][15:0];
                f.yn = uy[2][15:0];
                f.zl = uz[0][15:0];
                f.zm = uz[1][15:0];
                f.zn = uz[2][15:0];
            end
            pending.push_back(f);
        endfunction

        function void check_frame(frame_t got);
            frame_t exp_f;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected frame %h", $time, got);
                errors++;
                return;
            end
            exp_f = pending.pop_front();
            if (got.xl !== exp_f.xl || got.xm !== exp_f.xm || got.xn !== exp_f.xn)
            begin
                $display("%0t: x axis expected %0d %0d %0d actual %0d %0d %0d", $time,
                         exp_f.xl, exp_f.xm, exp_f.xn, got.xl, got.xm, got.xn);
                errors++;
            end
            if (got.yl !== exp_f.yl || got.ym !== exp_f.ym || got.yn !== exp_f.yn)
            begin
                $display("%0t: y axis expected %0d %0d %0d actual %0d %0d %0d", $time,
                         exp_f.yl, exp_f.ym, exp_f.yn, got.yl, got.ym, got.yn);
                errors++;
            end
            if (got.zl !== exp_f.zl || got.zm !== exp_f.zm || got.zn !== exp_f.zn)
            begin
                $display("%0t: z axis expected %0d %0d %0d actual %0d %0d %0d", $time,
                         exp_f.zl, exp_f.zm, exp_f.zn, got.zl, got.zm, got.zn);
                errors++;
            end
            if (got.degenerate !== exp_f.degenerate)
            begin
                $display("%0t: degenerate expected %b actual %b", $time,
                         exp_f.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   point_valid;
    logic   point_stall;
    point_t point_data;
    logic   frame_valid;
    logic   frame_stall;
    frame_t frame_data;

    frame_scoreboard sb;
    longint cycles;
    bit     quiet_tail;
    bit     hold_sink;
    bit     hold_started;
    int     sent;

    beam_local_frame_cosines #(.COORD_FRAC_BITS(CFB), .COS_FRAC_BITS(KFB)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point_data  (point_data),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_data  (frame_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_beam_local_frame_cosines NOT OK");
            $finish;
        end
    end

    // monitor both transfers at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && point_valid && !point_stall)
            sb.note_element(point_data);
        if (rst_n && frame_valid && !frame_stall)
            sb.check_frame(frame_data);
    end

    // receiver stall: random bursts, one long hold-off, none in the tail
    initial
    begin
        frame_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                frame_stall <= 1'b1;
                repeat (200) @(negedge clk);
                hold_sink = 1'b0;
                frame_stall <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                frame_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                frame_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 3))
            0: rand_coord = 24'($urandom);
            1: rand_coord = 24'sd8388607 - 24'($urandom_range(0, 3));
            2: rand_coord = -24'sd8388608 + 24'($urandom_range(0, 3));
            default: rand_coord = 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    // one element transfer, with an optional idle burst before it
    task automatic send_element(point_t p, bit may_idle);
        if (may_idle && $urandom_range(0, 5) == 0)
        begin
            point_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        point_valid <= 1'b1;
        point_data  <= p;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_pair(logic signed [23:0] ax, ay, az, bx, by, bz);
        point_t p;
        p = '{ax, ay, az, bx, by, bz};
        send_element(p, 1'b0);
    endtask

    initial
    begin
        point_t p;
        logic signed [23:0] t;
        sb = new();
        cycles = 0;
        sent = 0;
        quiet_tail = 1'b0;
        hold_sink = 1'b0;
        hold_started = 1'b0;
        rst_n = 1'b0;
        point_valid = 1'b0;
        point_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero axis, parallel offset, axis-aligned, extremes
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(24'sd1000, -24'sd5, 24'sd7, 24'sd1000, -24'sd5, 24'sd7);
        send_pair(0, 0, 0, 24'sd32768, 24'sd65536, 0);
        send_pair(0, 0, 0, -24'sd32768, -24'sd65536, 0);
        send_pair(24'sd100, 24'sd200, 24'sd3, 24'sd100 + 24'sd65536, 24'sd200 + 24'sd131072,
                  24'sd3);
        send_pair(0, 0, 0, 24'sd65536, 0, 0);
        send_pair(0, 0, 0, 0, 24'sd65536, 0);
        send_pair(0, 0, 0, 0, 0, 24'sd65536);
        send_pair(0, 0, 0, 0, 0, -24'sd1);
        send_pair(0, 0, 0, 24'sd1, 0, 0);
        send_pair(0, 0, 0, 0, 24'sd1, 0);
        send_pair(-24'sd8388608, -24'sd8388608, -24'sd8388608,
                  24'sd8388607, 24'sd8388607, 24'sd8388607);
        send_pair(24'sd8388607, 24'sd8388607, 24'sd8388607,
                  -24'sd8388608, -24'sd8388608, -24'sd8388608);
        send_pair(24'sd8388607, -24'sd8388608, 0, -24'sd8388608, 24'sd8388607, 24'sd1);
        send_pair(0, 0, 0, -24'sd65536, -24'sd131072, 24'sd1);
        send_pair(24'sd8388607, 0, 0, -24'sd8388608, 0, 0);
        send_pair(0, 24'sd8388607, 0, 0, -24'sd8388608, 24'sd8388607);
        send_pair(24'sd12345, 24'sd6789, -24'sd4321, 24'sd12346, 24'sd6789, -24'sd4321);

        // random: mostly general elements, some degenerate ones
        for (int k = 0; k < 1350; k++)
        begin
            if (k == 300 && !hold_started)
            begin
                hold_started = 1'b1;
                hold_sink = 1'b1;
            end
            if (k == 1150)
                quiet_tail = 1'b1;
            p.a_x = rand_coord();
            p.a_y = rand_coord();
            p.a_z = rand_coord();
            p.b_x = rand_coord();
            p.b_y = rand_coord();
            p.b_z = rand_coord();
            case ($urandom_range(0, 19))
                0:
                begin
                    p.b_x = p.a_x;
                    p.b_y = p.a_y;
                    p.b_z = p.a_z;
                end
                1:
                begin
                    // d along (0.5, 1, 0) scaled
                    t = 24'($signed($urandom_range(0, 60)) - 30);
                    p.b_x = p.a_x + t * 24'sd32768;
                    p.b_y = p.a_y + t * 24'sd65536;
                    p.b_z = p.a_z;
                end
                2:
                begin
                    p.b_x = p.a_x + 24'($signed($urandom_range(0, 4)) - 2);
                    p.b_y = p.a_y + 24'($signed($urandom_range(0, 4)) - 2);
                    p.b_z = p.a_z + 24'($signed($urandom_range(0, 4)) - 2);
                end
                default: ;
            endcase
            send_element(p, !quiet_tail);
        end
        point_valid <= 1'b0;

        // drain
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_beam_local_frame_cosines OK");
        else
            $display("tb_beam_local_frame_cosines NOT OK");
        $finish;
    end

endmodule
